@@ design/ffa_pkg.sv @@
package ffa_pkg;

  localparam int MAX_BLOCKS_DEF   = 256;
  localparam int HEADER_BYTES_DEF = 32;
  localparam logic [31:0] MAX_REQUEST_RST = 32'd100000000;
  localparam logic [39:0] HEAP_LIMIT_RST  = 40'hFF_FFFF_FFFF;

  localparam logic [1:0] CMD_ALLOC  = 2'd0;
  localparam logic [1:0] CMD_CALLOC = 2'd1;
  localparam logic [1:0] CMD_FREE   = 2'd2;
  localparam logic [1:0] CMD_RESIZE = 2'd3;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_ZERO      = 3'd1;
  localparam logic [2:0] ST_TOO_LARGE = 3'd2;
  localparam logic [2:0] ST_NO_SPACE  = 3'd3;
  localparam logic [2:0] ST_NOOP      = 3'd4;
  localparam logic [2:0] ST_BAD       = 3'd5;

  localparam logic [1:0] MOVE_NONE = 2'd0;
  localparam logic [1:0] MOVE_COPY = 2'd1;
  localparam logic [1:0] MOVE_ZERO = 2'd2;

  localparam logic [0:0] REG_MAX_REQUEST = 1'd0;
  localparam logic [0:0] REG_HEAP_LIMIT  = 1'd1;

  typedef enum logic [3:0] {
    S_IDLE, S_MUL, S_CHECK, S_HREAD, S_HWAIT, S_HDEC,
    S_SREAD, S_SWAIT, S_SDEC, S_APPEND, S_RESP
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic load;      // capture request
    logic mul;       // register product
    logic hread;     // read entry at handle
    logic sinit;     // start scan at 0
    logic sread;     // read entry at scan index
    logic sstep;     // advance scan
    logic take;      // mark scanned entry used, result ok
    logic append;    // append new block at heap top
    logic free_h;    // mark handle free
    logic keep;      // resize fits: return same handle
    logic set_st;    // record status
    logic [2:0] st;
    logic resp;      // present result
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [1:0] cmd;
    logic hnull;
    logic req_zero;
    logic req_big;
    logic h_unknown;
    logic h_free;
    logic h_fits;
    logic scan_end;
    logic scan_hit;
    logic table_full;
    logic over_limit;
    logic out_busy;
  } stat_t;

endpackage

@@ design/ffa_if.sv @@
interface ffa_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  cmd;
  logic [31:0] size;
  logic [31:0] count;
  logic [7:0]  handle;
  logic        handle_null;
  modport source(output valid, cmd, size, count, handle, handle_null, input ready);
  modport sink(input valid, cmd, size, count, handle, handle_null, output ready);
endinterface

interface ffa_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [7:0]  result_handle;
  logic        result_valid;
  logic [39:0] payload_offset;
  logic [1:0]  move_kind;
  logic [31:0] move_bytes;
  logic [8:0]  free_blocks;
  logic [39:0] free_bytes;
  logic [8:0]  used_blocks;
  logic [39:0] used_bytes;
  logic [13:0] header_bytes;
  modport source(output valid, status, result_handle, result_valid, payload_offset,
                 move_kind, move_bytes, free_blocks, free_bytes, used_blocks,
                 used_bytes, header_bytes, input ready);
  modport sink(input valid, status, result_handle, result_valid, payload_offset,
               move_kind, move_bytes, free_blocks, free_bytes, used_blocks,
               used_bytes, header_bytes, output ready);
endinterface

@@ design/ffa_ctrl.sv @@
module ffa_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  ffa_pkg::stat_t  st,
  output ffa_pkg::cmd_t   c
);

  ffa_pkg::state_t state, state_next;
  logic from_resize, from_resize_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ffa_pkg::S_IDLE;
      from_resize <= 1'b0;
    end else begin
      state <= state_next;
      from_resize <= from_resize_next;
    end
  end

  always_comb begin
    state_next = state;
    from_resize_next = from_resize;
    c = '0;
    in_ready = 1'b0;
    case (state)
      ffa_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          c.load = 1'b1;
          state_next = ffa_pkg::S_MUL;
        end
      end
      ffa_pkg::S_MUL: begin
        c.mul = 1'b1;
        state_next = ffa_pkg::S_CHECK;
      end
      ffa_pkg::S_CHECK: begin
        from_resize_next = 1'b0;
        c.set_st = 1'b1;
        case (st.cmd)
          ffa_pkg::CMD_FREE: begin
            if (st.hnull) begin
              c.st = ffa_pkg::ST_NOOP;
              state_next = ffa_pkg::S_RESP;
            end else if (st.h_unknown) begin
              c.st = ffa_pkg::ST_BAD;
              state_next = ffa_pkg::S_RESP;
            end else begin
              c.hread = 1'b1;
              state_next = ffa_pkg::S_HWAIT;
            end
          end
          default: begin
            if (st.req_zero) begin
              c.st = ffa_pkg::ST_ZERO;
              state_next = ffa_pkg::S_RESP;
            end else if (st.req_big) begin
              c.st = ffa_pkg::ST_TOO_LARGE;
              state_next = ffa_pkg::S_RESP;
            end else if (st.cmd == ffa_pkg::CMD_RESIZE && !st.hnull) begin
              if (st.h_unknown) begin
                c.st = ffa_pkg::ST_BAD;
                state_next = ffa_pkg::S_RESP;
              end else begin
                c.hread = 1'b1;
                from_resize_next = 1'b1;
                state_next = ffa_pkg::S_HWAIT;
              end
            end else begin
              c.st = ffa_pkg::ST_OK;
              c.sinit = 1'b1;
              state_next = ffa_pkg::S_SREAD;
            end
          end
        endcase
      end
      ffa_pkg::S_HREAD: state_next = ffa_pkg::S_HWAIT;
      ffa_pkg::S_HWAIT: state_next = ffa_pkg::S_HDEC;
      ffa_pkg::S_HDEC: begin
        c.set_st = 1'b1;
        if (st.h_free) begin
          c.st = (st.cmd == ffa_pkg::CMD_FREE) ? ffa_pkg::ST_NOOP : ffa_pkg::ST_BAD;
          state_next = ffa_pkg::S_RESP;
        end else if (st.cmd == ffa_pkg::CMD_FREE) begin
          c.st = ffa_pkg::ST_OK;
          c.free_h = 1'b1;
          state_next = ffa_pkg::S_RESP;
        end else if (st.h_fits) begin
          c.st = ffa_pkg::ST_OK;
          c.keep = 1'b1;
          state_next = ffa_pkg::S_RESP;
        end else begin
          c.st = ffa_pkg::ST_OK;
          c.sinit = 1'b1;
          state_next = ffa_pkg::S_SREAD;
        end
      end
      ffa_pkg::S_SREAD: begin
        if (st.scan_end) begin
          state_next = ffa_pkg::S_APPEND;
        end else begin
          c.sread = 1'b1;
          state_next = ffa_pkg::S_SWAIT;
        end
      end
      ffa_pkg::S_SWAIT: state_next = ffa_pkg::S_SDEC;
      ffa_pkg::S_SDEC: begin
        if (st.scan_hit) begin
          c.take = 1'b1;
          c.free_h = from_resize;
          state_next = ffa_pkg::S_RESP;
        end else begin
          c.sstep = 1'b1;
          state_next = ffa_pkg::S_SREAD;
        end
      end
      ffa_pkg::S_APPEND: begin
        if (st.table_full || st.over_limit) begin
          c.set_st = 1'b1;
          c.st = ffa_pkg::ST_NO_SPACE;
        end else begin
          c.append = 1'b1;
          c.free_h = from_resize;
        end
        state_next = ffa_pkg::S_RESP;
      end
      ffa_pkg::S_RESP: begin
        if (!st.out_busy) begin
          c.resp = 1'b1;
          state_next = ffa_pkg::S_IDLE;
        end
      end
      default: state_next = ffa_pkg::S_IDLE;
    endcase
  end

`ifndef SYNTHESIS
  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> state == ffa_pkg::S_IDLE) else $error("ready outside idle");
  a_load_mul: assert property (@(posedge clk) disable iff (rst)
    c.load |=> state == ffa_pkg::S_MUL) else $error("load not followed by multiply");
  a_take_append: assert property (@(posedge clk) disable iff (rst)
    !(c.take && c.append)) else $error("take and append together");
`endif

endmodule

@@ design/ffa_dp.sv @@
module ffa_dp #(
  parameter int MAX_BLOCKS   = ffa_pkg::MAX_BLOCKS_DEF,
  parameter int HEADER_BYTES = ffa_pkg::HEADER_BYTES_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  ffa_pkg::cmd_t  c,
  output ffa_pkg::stat_t st,
  input  logic           cfg_we,
  input  logic [0:0]     cfg_index,
  input  logic [39:0]    cfg_data,
  ffa_in_if.sink         in_ch,
  ffa_out_if.source      out_ch
);

  localparam int AW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
  localparam int CW = $clog2(MAX_BLOCKS + 1);

  logic [31:0] max_request;
  logic [39:0] heap_limit;

  logic [1:0]  r_cmd;
  logic [31:0] r_size, r_count;
  logic [7:0]  r_handle;
  logic        r_hnull;
  logic [63:0] prod;
  logic [31:0] req;

  // block table: size, free mark, offset in one word
  logic [72:0] mem [MAX_BLOCKS];
  logic [72:0] rd;
  logic [AW-1:0] raddr;

  logic [CW-1:0] block_count, scan;
  logic [39:0] heap_top, free_bytes, all_bytes;
  logic [CW-1:0] free_blocks;
  logic [31:0] old_size;
  logic [AW-1:0] res_idx;
  logic [39:0] res_off;
  logic [2:0]  status;
  logic        res_valid;
  logic [1:0]  mkind;
  logic [31:0] mbytes;

  logic [40:0] new_top;
  logic        zero_in;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_request <= ffa_pkg::MAX_REQUEST_RST;
      heap_limit  <= ffa_pkg::HEAP_LIMIT_RST;
    end else if (cfg_we) begin
      if (cfg_index == ffa_pkg::REG_MAX_REQUEST) max_request <= cfg_data[31:0];
      else heap_limit <= cfg_data;
    end
  end

  assign zero_in = (r_size == 32'd0) || (r_cmd == ffa_pkg::CMD_CALLOC && r_count == 32'd0);
  assign req     = (r_cmd == ffa_pkg::CMD_CALLOC) ? prod[31:0] : r_size;
  assign new_top = {1'b0, heap_top} + 41'(HEADER_BYTES) + 41'(req);

  always_comb begin
    st.cmd        = r_cmd;
    st.hnull      = r_hnull;
    st.req_zero   = zero_in;
    st.req_big    = (r_cmd == ffa_pkg::CMD_CALLOC) ? (prod > 64'(max_request))
                                                   : (r_size > max_request);
    st.h_unknown  = (17'(r_handle) >= 17'(block_count)) || (17'(r_handle) >= 17'(MAX_BLOCKS));
    st.h_free     = rd[40];
    st.h_fits     = rd[72:41] >= r_size;
    st.scan_end   = (scan >= block_count);
    st.scan_hit   = rd[40] && (rd[72:41] >= req);
    st.table_full = (17'(block_count) >= 17'(MAX_BLOCKS));
    st.over_limit = new_top > {1'b0, heap_limit};
    st.out_busy   = out_ch.valid && !out_ch.ready;
  end

  assign raddr = c.hread ? r_handle[AW-1:0] : scan[AW-1:0];

  always_ff @(posedge clk) begin
    if (c.hread || c.sread) rd <= mem[raddr];
    if (c.take) mem[scan[AW-1:0]][40] <= 1'b0;
    else if (c.append) mem[block_count[AW-1:0]] <= {req, 1'b0, heap_top};
    if (c.free_h && !c.keep) mem[r_handle[AW-1:0]][40] <= 1'b1;
  end

  always_ff @(posedge clk) begin
    if (c.load) begin
      r_cmd    <= in_ch.cmd;
      r_size   <= in_ch.size;
      r_count  <= in_ch.count;
      r_handle <= in_ch.handle;
      r_hnull  <= in_ch.handle_null;
      res_valid <= 1'b0;
      mkind    <= ffa_pkg::MOVE_NONE;
      mbytes   <= '0;
    end
    if (c.mul) prod <= r_count * r_size;
    if (c.hread) scan <= '0;
    if (c.sinit) scan <= '0;
    if (c.sstep) scan <= scan + 1'b1;
    if (c.set_st) status <= c.st;
    // entry at handle is still in rd when the resize scan starts; its size is kept in old_size
    if (c.hread || (c.keep)) old_size <= old_size;
    if (c.sinit && r_cmd == ffa_pkg::CMD_RESIZE && !r_hnull) old_size <= rd[72:41];
    if (c.keep) begin
      res_valid <= 1'b1;
      res_idx   <= r_handle[AW-1:0];
      res_off   <= rd[39:0];
    end
    if (c.take || c.append) begin
      res_valid <= 1'b1;
      res_idx   <= c.take ? scan[AW-1:0] : block_count[AW-1:0];
      res_off   <= c.take ? rd[39:0] : heap_top;
      if (r_cmd == ffa_pkg::CMD_CALLOC) begin
        mkind  <= ffa_pkg::MOVE_ZERO;
        mbytes <= prod[31:0];
      end else if (c.free_h) begin
        mkind  <= ffa_pkg::MOVE_COPY;
        mbytes <= old_size;
      end
    end
  end

  logic [39:0] fb_add, fb_sub;
  assign fb_add = (c.free_h && !c.keep) ?
                  ((r_cmd == ffa_pkg::CMD_FREE) ? 40'(rd[72:41]) : 40'(old_size)) : 40'd0;
  assign fb_sub = c.take ? 40'(rd[72:41]) : 40'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      block_count <= '0;
      heap_top    <= '0;
      free_blocks <= '0;
      free_bytes  <= '0;
      all_bytes   <= '0;
    end else begin
      if (c.append) begin
        block_count <= block_count + 1'b1;
        heap_top    <= new_top[39:0];
        all_bytes   <= all_bytes + 40'(req);
      end
      free_bytes  <= free_bytes + fb_add - fb_sub;
      free_blocks <= free_blocks + CW'(c.free_h && !c.keep) - CW'(c.take);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) out_ch.valid <= 1'b0;
    else if (c.resp) out_ch.valid <= 1'b1;
    else if (out_ch.ready) out_ch.valid <= 1'b0;
    if (c.resp) begin
      out_ch.status         <= status;
      out_ch.result_valid   <= res_valid;
      out_ch.result_handle  <= res_valid ? 8'(res_idx) : 8'd0;
      out_ch.payload_offset <= res_valid ? res_off + 40'(HEADER_BYTES) : 40'd0;
      out_ch.move_kind      <= mkind;
      out_ch.move_bytes     <= mbytes;
      out_ch.free_blocks    <= 9'(free_blocks);
      out_ch.free_bytes     <= free_bytes;
      out_ch.used_blocks    <= 9'(block_count);
      out_ch.used_bytes     <= all_bytes;
      out_ch.header_bytes   <= 14'(32'(block_count) * HEADER_BYTES);
    end
  end

`ifndef SYNTHESIS
  a_free_le_count: assert property (@(posedge clk) disable iff (rst)
    free_blocks <= block_count) else $error("free count above block count");
  a_append_room: assert property (@(posedge clk) disable iff (rst)
    c.append |-> 17'(block_count) < 17'(MAX_BLOCKS)) else $error("append into full table");
  a_top_grows: assert property (@(posedge clk) disable iff (rst)
    c.append |=> heap_top > $past(heap_top)) else $error("heap top did not grow");
`endif

endmodule

@@ design/first_fit_block_allocator_core.sv @@
// First-fit heap block allocator without splitting or merging. One request is
// worked at a time: the request is captured, its product held in one product register
// and the request decoded; then the first-fit scan reads the block table entry by
// entry through the states SREAD, SWAIT and SDEC, and appends at the heap top if no
// free entry fits. Free and a fitting resize read only the entry at the handle.
// The result sits in an output register while the next request waits only for the
// controller to return to idle.
module first_fit_block_allocator_core #(
  parameter int MAX_BLOCKS   = ffa_pkg::MAX_BLOCKS_DEF,
  parameter int HEADER_BYTES = ffa_pkg::HEADER_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  logic [39:0] cfg_data,
  ffa_in_if.sink      in_ch,
  ffa_out_if.source   out_ch
);

  ffa_pkg::cmd_t  c;
  ffa_pkg::stat_t st;

  ffa_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .st(st), .c(c)
  );

  ffa_dp #(.MAX_BLOCKS(MAX_BLOCKS), .HEADER_BYTES(HEADER_BYTES)) u_dp (
    .clk(clk), .rst(rst), .c(c), .st(st), .cfg_we(cfg_we),
    .cfg_index(cfg_index), .cfg_data(cfg_data), .in_ch(in_ch), .out_ch(out_ch)
  );

endmodule
